>>> sv/off_pkg.sv
// ----------------------------------------------------------------------------
// off_pkg
// types, codes and constants shared by the observation flag filter files
// ----------------------------------------------------------------------------
`default_nettype none

package off_pkg;

  // field widths
  localparam int unsigned OPCODE_WIDTH = 2;
  localparam int unsigned FLAG_WIDTH   = 6;
  localparam int unsigned PACKED_WIDTH = 16;
  localparam int unsigned GRAD_WIDTH   = 8;
  localparam int unsigned INDEX_WIDTH  = 5;
  localparam int unsigned STAT_WIDTH   = 32;
  localparam int unsigned COUNT_WIDTH  = 32;

  localparam int unsigned BG_WIDTH      = 7;
  localparam int unsigned PK_WIDTH      = 10;
  localparam int unsigned GRAD_LIM_WIDTH = 9;

  // configuration port
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 10;

  // divide by 100 as multiply by reciprocal, exact over the packed range
  localparam int unsigned            DIV100_MUL_WIDTH = 17;
  localparam logic [DIV100_MUL_WIDTH-1:0] DIV100_MUL  = 17'd83887;
  localparam int unsigned            DIV100_SHIFT     = 23;
  localparam int unsigned            DIV100_PROD_WIDTH = PACKED_WIDTH + DIV100_MUL_WIDTH;

  // counter storage
  localparam int unsigned NUM_FLAGGED  = 6;
  localparam int unsigned NUM_ACCEPTED = 5;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_OBSERVE = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_BG_LIMIT        = 3'd0,
    CFG_PK_LIMIT        = 3'd1,
    CFG_GRAD_LIMIT      = 3'd2,
    CFG_ACCEPT_OVERLOAD = 3'd3,
    CFG_ACCEPT_EDGE     = 3'd4
  } cfg_idx_e;

  // flag bit positions, also the flagged counter slots
  localparam int unsigned FLAG_BG     = 0;
  localparam int unsigned FLAG_PK     = 1;
  localparam int unsigned FLAG_TOONEG = 2;
  localparam int unsigned FLAG_GRAD   = 3;
  localparam int unsigned FLAG_OVL    = 4;
  localparam int unsigned FLAG_BORDER = 5;

  // accepted counter slots
  localparam int unsigned ACC_BG   = 0;
  localparam int unsigned ACC_PK   = 1;
  localparam int unsigned ACC_GRAD = 2;
  localparam int unsigned ACC_OVL  = 3;
  localparam int unsigned ACC_EDGE = 4;

  // statistic indexes
  localparam logic [INDEX_WIDTH-1:0] STAT_ACC_BASE    = 5'd6;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_BASE    = 5'd11;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_BG      = 5'd11;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_PK      = 5'd12;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_GRAD    = 5'd13;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_ACC_BG  = 5'd14;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_ACC_PK  = 5'd15;
  localparam logic [INDEX_WIDTH-1:0] STAT_MAX_ACC_GRAD = 5'd16;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [OPCODE_WIDTH-1:0] opcode;
    logic [FLAG_WIDTH-1:0]   flag_bits;
    logic [PACKED_WIDTH-1:0] packed_whole;
    logic [GRAD_WIDTH-1:0]   gradient_frac;
    logic [INDEX_WIDTH-1:0]  stat_index;
  } req_t;

endpackage

`default_nettype wire

>>> sv/off_req_if.sv
// ----------------------------------------------------------------------------
// off_req_if
// request channel of the observation flag filter
// ----------------------------------------------------------------------------
`default_nettype none

interface off_req_if;
  logic                             valid;
  logic                             ready;
  logic [off_pkg::OPCODE_WIDTH-1:0] opcode;
  logic [off_pkg::FLAG_WIDTH-1:0]   flag_bits;
  logic [off_pkg::PACKED_WIDTH-1:0] packed_whole;
  logic [off_pkg::GRAD_WIDTH-1:0]   gradient_frac;
  logic [off_pkg::INDEX_WIDTH-1:0]  stat_index;

  modport source (
    output valid, opcode, flag_bits, packed_whole, gradient_frac, stat_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, flag_bits, packed_whole, gradient_frac, stat_index,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/off_rsp_if.sv
// ----------------------------------------------------------------------------
// off_rsp_if
// result channel of the observation flag filter
// ----------------------------------------------------------------------------
`default_nettype none

interface off_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [off_pkg::STAT_WIDTH-1:0] stat_value;

  modport source (
    output valid, accepted, stat_value,
    input  ready
  );

  modport sink (
    input  valid, accepted, stat_value,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/observation_flag_filter_unit.sv
// ----------------------------------------------------------------------------
// observation_flag_filter_unit
// per-observation flag acceptance with flagged/accepted counters and maxima
// ----------------------------------------------------------------------------
// path: a request is held in the input register, then passes
//   combinationally into the result register once that is free or draining
// throughput: one request per cycle while the result is taken; the
//   statistics update loop closes in the single pass stage, so
//   back-to-back requests see each other's updates
// reset: asynchronous, clears limits, switches, counters, maxima and valids
`default_nettype none

module observation_flag_filter_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  off_req_if.sink                                 req_i,
  off_rsp_if.source                               rsp_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [off_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  wire logic [off_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [off_pkg::BG_WIDTH-1:0]       bg_limit_q;
  logic [off_pkg::PK_WIDTH-1:0]       pk_limit_q;
  logic [off_pkg::GRAD_LIM_WIDTH-1:0] grad_limit_q;
  logic                               accept_overload_q;
  logic                               accept_edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_limit_q        <= '0;
      pk_limit_q        <= '0;
      grad_limit_q      <= '0;
      accept_overload_q <= 1'b0;
      accept_edge_q     <= 1'b0;
    end else if (cfg_we_i) begin
      // indexes past the register list are dropped
      unique case (cfg_idx_i)
        off_pkg::CFG_BG_LIMIT:        bg_limit_q <= cfg_data_i[off_pkg::BG_WIDTH-1:0];
        off_pkg::CFG_PK_LIMIT:        pk_limit_q <= cfg_data_i[off_pkg::PK_WIDTH-1:0];
        off_pkg::CFG_GRAD_LIMIT:
          grad_limit_q <= cfg_data_i[off_pkg::GRAD_LIM_WIDTH-1:0];
        off_pkg::CFG_ACCEPT_OVERLOAD: accept_overload_q <= cfg_data_i[0];
        off_pkg::CFG_ACCEPT_EDGE:     accept_edge_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake: input register, result register
  // --------------------------------------------------------------------------
  off_pkg::req_t in_q;
  logic          in_valid_q;
  logic          rsp_valid_q;
  logic          rsp_accepted_q;
  logic          rsp_accepted_d;
  logic [off_pkg::STAT_WIDTH-1:0] rsp_stat_q;
  logic [off_pkg::STAT_WIDTH-1:0] rsp_stat_d;

  logic req_fire;
  logic advance;

  // the pass stage moves whenever the result register is free or draining
  assign advance     = in_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.opcode        <= req_i.opcode;
      in_q.flag_bits     <= req_i.flag_bits;
      in_q.packed_whole  <= req_i.packed_whole;
      in_q.gradient_frac <= req_i.gradient_frac;
      in_q.stat_index    <= req_i.stat_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_accepted_q <= rsp_accepted_d;
      rsp_stat_q     <= rsp_stat_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.accepted   = rsp_accepted_q;
  assign rsp_o.stat_value = rsp_stat_q;

  // --------------------------------------------------------------------------
  // unpack peak and background: q = whole / 100 by reciprocal multiply,
  // remainder by shift-add of q * 100 (64 + 32 + 4)
  // --------------------------------------------------------------------------
  logic [off_pkg::DIV100_PROD_WIDTH-1:0] div_prod;
  logic [off_pkg::PK_WIDTH-1:0]          pk_val;
  logic [off_pkg::PACKED_WIDTH-1:0]      pk_ext;
  logic [off_pkg::PACKED_WIDTH-1:0]      pk_times100;
  logic [off_pkg::PACKED_WIDTH-1:0]      bg_full;
  logic [off_pkg::BG_WIDTH-1:0]          bg_val;
  logic [off_pkg::GRAD_WIDTH-1:0]        grad_val;

  assign div_prod = off_pkg::DIV100_PROD_WIDTH'(in_q.packed_whole)
                  * off_pkg::DIV100_PROD_WIDTH'(off_pkg::DIV100_MUL);
  // a 16-bit whole gives a peak of at most 655, so it always fits the 10-bit peak field
  assign pk_val      = div_prod[off_pkg::DIV100_SHIFT +: off_pkg::PK_WIDTH];
  assign pk_ext      = off_pkg::PACKED_WIDTH'(pk_val);
  assign pk_times100 = (pk_ext << 6) + (pk_ext << 5) + (pk_ext << 2);
  assign bg_full     = in_q.packed_whole - pk_times100;
  assign bg_val      = bg_full[off_pkg::BG_WIDTH-1:0];
  assign grad_val    = in_q.gradient_frac;

  // --------------------------------------------------------------------------
  // statistics state
  // --------------------------------------------------------------------------
  off_pkg::count_t flagged_q [off_pkg::NUM_FLAGGED];
  off_pkg::count_t flagged_d [off_pkg::NUM_FLAGGED];
  off_pkg::count_t acc_q     [off_pkg::NUM_ACCEPTED];
  off_pkg::count_t acc_d     [off_pkg::NUM_ACCEPTED];

  logic [off_pkg::BG_WIDTH-1:0]   max_bg_q,   max_bg_d;
  logic [off_pkg::PK_WIDTH-1:0]   max_pk_q,   max_pk_d;
  logic [off_pkg::GRAD_WIDTH-1:0] max_grad_q, max_grad_d;
  logic [off_pkg::BG_WIDTH-1:0]   max_acc_bg_q,   max_acc_bg_d;
  logic [off_pkg::PK_WIDTH-1:0]   max_acc_pk_q,   max_acc_pk_d;
  logic [off_pkg::GRAD_WIDTH-1:0] max_acc_grad_q, max_acc_grad_d;

  function automatic off_pkg::count_t sat_inc(input off_pkg::count_t c);
    return (&c) ? c : c + off_pkg::COUNT_WIDTH'(1);
  endfunction

  // per-category decisions
  logic [off_pkg::FLAG_WIDTH-1:0] flags;
  logic bg_ok, pk_ok, grad_ok;
  logic [off_pkg::FLAG_WIDTH-1:0] cat_pass;   // category lets the item through
  logic [off_pkg::NUM_ACCEPTED-1:0] acc_hit;  // category bumps its accepted count
  logic is_observe, is_read, is_clear, any_flag;

  assign flags   = in_q.flag_bits;
  // a zero limit disables acceptance; otherwise strictly below the limit
  assign bg_ok   = (bg_limit_q != '0) && (bg_val < bg_limit_q);
  assign pk_ok   = (pk_limit_q != '0) && (pk_val < pk_limit_q);
  assign grad_ok = (grad_limit_q != '0)
                && (off_pkg::GRAD_LIM_WIDTH'(grad_val) < grad_limit_q);

  assign acc_hit[off_pkg::ACC_BG]   = flags[off_pkg::FLAG_BG]   && bg_ok;
  assign acc_hit[off_pkg::ACC_PK]   = flags[off_pkg::FLAG_PK]   && pk_ok;
  assign acc_hit[off_pkg::ACC_GRAD] = flags[off_pkg::FLAG_GRAD] && grad_ok;
  assign acc_hit[off_pkg::ACC_OVL]  = flags[off_pkg::FLAG_OVL]  && accept_overload_q;
  assign acc_hit[off_pkg::ACC_EDGE] = flags[off_pkg::FLAG_BORDER] && accept_edge_q;

  assign cat_pass[off_pkg::FLAG_BG]     = !flags[off_pkg::FLAG_BG]   || bg_ok;
  assign cat_pass[off_pkg::FLAG_PK]     = !flags[off_pkg::FLAG_PK]   || pk_ok;
  assign cat_pass[off_pkg::FLAG_TOONEG] = !flags[off_pkg::FLAG_TOONEG];
  assign cat_pass[off_pkg::FLAG_GRAD]   = !flags[off_pkg::FLAG_GRAD] || grad_ok;
  assign cat_pass[off_pkg::FLAG_OVL]    = !flags[off_pkg::FLAG_OVL]  || accept_overload_q;
  assign cat_pass[off_pkg::FLAG_BORDER] = !flags[off_pkg::FLAG_BORDER] || accept_edge_q;

  assign is_observe = (in_q.opcode == off_pkg::OP_OBSERVE);
  assign is_read    = (in_q.opcode == off_pkg::OP_READ);
  assign is_clear   = (in_q.opcode == off_pkg::OP_CLEAR);
  assign any_flag   = (flags != '0);

  // result fields
  always_comb begin
    rsp_accepted_d = 1'b0;
    rsp_stat_d     = '0;
    if (is_observe) begin
      // no flag: accepted outright
      rsp_accepted_d = !any_flag || (&cat_pass);
    end
    if (is_read) begin
      priority if (in_q.stat_index < off_pkg::STAT_ACC_BASE) begin
        rsp_stat_d = flagged_q[in_q.stat_index[2:0]];
      end else if (in_q.stat_index < off_pkg::STAT_MAX_BASE) begin
        rsp_stat_d = acc_q[3'(in_q.stat_index - off_pkg::STAT_ACC_BASE)];
      end else if (in_q.stat_index == off_pkg::STAT_MAX_BG) begin
        rsp_stat_d = off_pkg::STAT_WIDTH'(max_bg_q);
      end else if (in_q.stat_index == off_pkg::STAT_MAX_PK) begin
        rsp_stat_d = off_pkg::STAT_WIDTH'(max_pk_q);
      end else if (in_q.stat_index == off_pkg::STAT_MAX_GRAD) begin
        rsp_stat_d = off_pkg::STAT_WIDTH'(max_grad_q);
      end else if (in_q.stat_index == off_pkg::STAT_MAX_ACC_BG) begin
        rsp_stat_d = off_pkg::STAT_WIDTH'(max_acc_bg_q);
      end else if (in_q.stat_index == off_pkg::STAT_MAX_ACC_PK) begin
        rsp_stat_d = off_pkg::STAT_WIDTH'(max_acc_pk_q);
      end else if (in_q.stat_index == off_pkg::STAT_MAX_ACC_GRAD) begin
        rsp_stat_d = off_pkg::STAT_WIDTH'(max_acc_grad_q);
      end else begin
        // indexes past the statistic list read as zero
        rsp_stat_d = '0;
      end
    end
  end

  // statistics next state
  always_comb begin
    for (int i = 0; i < off_pkg::NUM_FLAGGED; i++) begin
      flagged_d[i] = flagged_q[i];
    end
    for (int i = 0; i < off_pkg::NUM_ACCEPTED; i++) begin
      acc_d[i] = acc_q[i];
    end
    max_bg_d       = max_bg_q;
    max_pk_d       = max_pk_q;
    max_grad_d     = max_grad_q;
    max_acc_bg_d   = max_acc_bg_q;
    max_acc_pk_d   = max_acc_pk_q;
    max_acc_grad_d = max_acc_grad_q;

    if (is_clear) begin
      for (int i = 0; i < off_pkg::NUM_FLAGGED; i++) begin
        flagged_d[i] = '0;
      end
      for (int i = 0; i < off_pkg::NUM_ACCEPTED; i++) begin
        acc_d[i] = '0;
      end
      max_bg_d       = '0;
      max_pk_d       = '0;
      max_grad_d     = '0;
      max_acc_bg_d   = '0;
      max_acc_pk_d   = '0;
      max_acc_grad_d = '0;
    end else if (is_observe && any_flag) begin
      if (bg_val > max_bg_q)     max_bg_d   = bg_val;
      if (pk_val > max_pk_q)     max_pk_d   = pk_val;
      if (grad_val > max_grad_q) max_grad_d = grad_val;
      for (int i = 0; i < off_pkg::NUM_FLAGGED; i++) begin
        if (flags[i]) flagged_d[i] = sat_inc(flagged_q[i]);
      end
      for (int i = 0; i < off_pkg::NUM_ACCEPTED; i++) begin
        if (acc_hit[i]) acc_d[i] = sat_inc(acc_q[i]);
      end
      if (acc_hit[off_pkg::ACC_BG] && (bg_val > max_acc_bg_q)) begin
        max_acc_bg_d = bg_val;
      end
      if (acc_hit[off_pkg::ACC_PK] && (pk_val > max_acc_pk_q)) begin
        max_acc_pk_d = pk_val;
      end
      if (acc_hit[off_pkg::ACC_GRAD] && (grad_val > max_acc_grad_q)) begin
        max_acc_grad_d = grad_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < off_pkg::NUM_FLAGGED; i++) begin
        flagged_q[i] <= '0;
      end
      for (int i = 0; i < off_pkg::NUM_ACCEPTED; i++) begin
        acc_q[i] <= '0;
      end
      max_bg_q       <= '0;
      max_pk_q       <= '0;
      max_grad_q     <= '0;
      max_acc_bg_q   <= '0;
      max_acc_pk_q   <= '0;
      max_acc_grad_q <= '0;
    end else if (advance) begin
      for (int i = 0; i < off_pkg::NUM_FLAGGED; i++) begin
        flagged_q[i] <= flagged_d[i];
      end
      for (int i = 0; i < off_pkg::NUM_ACCEPTED; i++) begin
        acc_q[i] <= acc_d[i];
      end
      max_bg_q       <= max_bg_d;
      max_pk_q       <= max_pk_d;
      max_grad_q     <= max_grad_d;
      max_acc_bg_q   <= max_acc_bg_d;
      max_acc_pk_q   <= max_acc_pk_d;
      max_acc_grad_q <= max_acc_grad_d;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the request side only stalls when both stages hold a request and the
  // result is not being taken
  a_ready_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_valid_q && rsp_valid_q && !rsp_o.ready))
    else $error("request stalled without backpressure");

  // only observe requests can report acceptance
  a_accept_only_observe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_observe) |=> !rsp_accepted_q)
    else $error("non-observe request reported accepted");

  // a clear request leaves counters and maxima at zero
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_clear) |=>
      (flagged_q[off_pkg::FLAG_TOONEG] == '0) && (acc_q[off_pkg::ACC_BG] == '0)
      && (max_pk_q == '0) && (max_acc_grad_q == '0))
    else $error("statistics not cleared");

  // an accepted count never exceeds its flagged count
  a_acc_le_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q[off_pkg::ACC_EDGE] <= flagged_q[off_pkg::FLAG_BORDER])
    else $error("accepted count above flagged count");

endmodule

`default_nettype wire
